/* rtl/lbe_pkg.sv */
// ----------------------------------------------------------------------------
// lbe_pkg
// Shared types and constants of the landmark lower bound engine: table
// geometry, table entry layout and the request words between the modules.
// ----------------------------------------------------------------------------
package lbe_pkg;

	localparam int MAX_LANDMARKS = 16;
	localparam int MAX_STOPS     = 4096;
	localparam int DUR_BITS      = 20;
	localparam int LM_BITS       = $clog2(MAX_LANDMARKS);
	localparam int STOP_BITS     = $clog2(MAX_STOPS);
	localparam int ADDR_BITS     = LM_BITS + STOP_BITS;
	localparam int CNT_BITS      = $clog2(MAX_LANDMARKS + 1);
	localparam int CFG_BITS      = 5;

	localparam logic [CNT_BITS-1:0] LM_LIMIT = CNT_BITS'(MAX_LANDMARKS);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DRAIN
	} state_t;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic {
		DIR_TO_LM   = 1'b0,
		DIR_FROM_LM = 1'b1
	} dir_t;

	typedef struct packed {
		logic                known;
		logic [DUR_BITS-1:0] dur;
	} entry_t;

	typedef struct packed {
		logic                 valid;
		logic                 dir;
		logic [ADDR_BITS-1:0] addr;
		entry_t               entry;
	} wr_req_t;

	typedef struct packed {
		logic                 valid;
		logic [LM_BITS-1:0]   lm;
		logic [STOP_BITS-1:0] s1;
		logic [STOP_BITS-1:0] s2;
	} rd_req_t;

	typedef struct packed {
		logic   valid;
		entry_t to_a;
		entry_t to_b;
		entry_t from_a;
		entry_t from_b;
	} rd_data_t;

endpackage

/* rtl/landmark_lower_bound_engine_top.sv */
// ----------------------------------------------------------------------------
// landmark_lower_bound_engine_top
// Landmark lower bound engine: stores landmark travel durations and answers
// lower-bound queries between two stops.
// ----------------------------------------------------------------------------
// After reset the duration table is swept to unknown, one entry per direction
// each cycle, and busy stays high until the sweep is done; configuration
// writes are taken during that time. A write command leaves busy low. A
// query holds busy while both direction memories are read at two stops, one
// landmark per cycle (landmarks_in_use taken as at most 16), while one more
// read state ends the walk and while the read, difference and maximum
// pipeline drains. The result word is shown for one cycle with done high, in
// the first cycle with busy low, and must be taken then.
module landmark_lower_bound_engine_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lbe_pkg::CFG_BITS-1:0]  cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [lbe_pkg::LM_BITS-1:0]   landmark_index,
	input  logic [lbe_pkg::STOP_BITS-1:0] stop_index,
	input  logic [lbe_pkg::STOP_BITS-1:0] second_stop,
	input  logic                          direction,
	input  logic [lbe_pkg::DUR_BITS-1:0]  duration_value,
	input  logic                          duration_known,
	output logic                          done,
	output logic [lbe_pkg::DUR_BITS-1:0]  lower_bound
);
	import lbe_pkg::*;

	logic [CFG_BITS-1:0] landmarks_in_use_q;
	wr_req_t             wr;
	rd_req_t             rd;
	rd_data_t            rd_data;
	logic                clearing;
	logic                clr_best;
	logic [DUR_BITS-1:0] best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			landmarks_in_use_q <= '0;
		end else if (cfg_we) begin
			landmarks_in_use_q <= cfg_wdata;
		end
	end

	lbe_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd       (rd),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	lbe_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr_best (clr_best),
		.rd_data  (rd_data),
		.best     (best)
	);

	lbe_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.func             (func),
		.landmark_index   (landmark_index),
		.stop_index       (stop_index),
		.second_stop      (second_stop),
		.direction        (direction),
		.duration_value   (duration_value),
		.duration_known   (duration_known),
		.landmarks_in_use (landmarks_in_use_q),
		.clearing         (clearing),
		.best             (best),
		.busy             (busy),
		.clr_best         (clr_best),
		.wr               (wr),
		.rd               (rd),
		.done             (done),
		.lower_bound      (lower_bound)
	);

endmodule

/* rtl/lbe_store.sv */
// ----------------------------------------------------------------------------
// lbe_store
// Duration table: one memory per direction, addressed by landmark and stop,
// one write port and two registered read ports each. Cleared after reset.
// ----------------------------------------------------------------------------
module lbe_store (
	input  logic             clk,
	input  logic             arst_n,
	input  lbe_pkg::wr_req_t wr,
	input  lbe_pkg::rd_req_t rd,
	output lbe_pkg::rd_data_t rd_data,
	output logic             clearing
);
	import lbe_pkg::*;

	localparam int DEPTH = 1 << ADDR_BITS;

	entry_t mem_to   [0:DEPTH-1];
	entry_t mem_from [0:DEPTH-1];

	logic                 clearing_q;
	logic [ADDR_BITS-1:0] clr_addr_q;
	logic                 rd_valid_s1;
	entry_t               to_a_s1, to_b_s1, from_a_s1, from_b_s1;
	logic [ADDR_BITS-1:0] addr_a, addr_b;

	assign addr_a   = {rd.lm, rd.s1};
	assign addr_b   = {rd.lm, rd.s2};
	assign clearing = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd.valid;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
				if (clr_addr_q == '1) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

	// write port, shared by the clearing sweep
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_to[clr_addr_q]   <= '0;
			mem_from[clr_addr_q] <= '0;
		end else if (wr.valid) begin
			if (wr.dir == DIR_FROM_LM) begin
				mem_from[wr.addr] <= wr.entry;
			end else begin
				mem_to[wr.addr] <= wr.entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd.valid) begin
			to_a_s1   <= mem_to[addr_a];
			to_b_s1   <= mem_to[addr_b];
			from_a_s1 <= mem_from[addr_a];
			from_b_s1 <= mem_from[addr_b];
		end
	end

	assign rd_data = '{valid: rd_valid_s1, to_a: to_a_s1, to_b: to_b_s1,
		from_a: from_a_s1, from_b: from_b_s1};

endmodule

/* rtl/lbe_accum.sv */
// ----------------------------------------------------------------------------
// lbe_accum
// Forms the two triangle-inequality differences of one landmark and keeps
// the running maximum over the landmarks of a query.
// ----------------------------------------------------------------------------
module lbe_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clr_best,
	input  lbe_pkg::rd_data_t           rd_data,
	output logic [lbe_pkg::DUR_BITS-1:0] best
);
	import lbe_pkg::*;

	logic                v_s2;
	logic [DUR_BITS-1:0] d_to_s2, d_from_s2;
	logic [DUR_BITS-1:0] d_to, d_from, d_max;
	logic [DUR_BITS-1:0] best_q;

	always_comb begin
		d_to   = '0;
		d_from = '0;
		if (rd_data.to_a.known && rd_data.to_b.known &&
			rd_data.to_a.dur > rd_data.to_b.dur) begin
			d_to = rd_data.to_a.dur - rd_data.to_b.dur;
		end
		if (rd_data.from_b.known && rd_data.from_a.known &&
			rd_data.from_b.dur > rd_data.from_a.dur) begin
			d_from = rd_data.from_b.dur - rd_data.from_a.dur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= rd_data.valid;
		end
	end

	always_ff @(posedge clk) begin
		d_to_s2   <= d_to;
		d_from_s2 <= d_from;
	end

	always_comb begin
		d_max = (d_to_s2 > d_from_s2) ? d_to_s2 : d_from_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (clr_best) begin
			best_q <= '0;
		end else if (v_s2 && d_max > best_q) begin
			best_q <= d_max;
		end
	end

	assign best = best_q;

endmodule

/* rtl/lbe_ctrl.sv */
// ----------------------------------------------------------------------------
// lbe_ctrl
// Sequencer: waits out the table clear, takes commands, walks the landmarks
// of a query one per cycle and emits the result word.
// ----------------------------------------------------------------------------
module lbe_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          func,
	input  logic [lbe_pkg::LM_BITS-1:0]   landmark_index,
	input  logic [lbe_pkg::STOP_BITS-1:0] stop_index,
	input  logic [lbe_pkg::STOP_BITS-1:0] second_stop,
	input  logic                          direction,
	input  logic [lbe_pkg::DUR_BITS-1:0]  duration_value,
	input  logic                          duration_known,
	input  logic [lbe_pkg::CFG_BITS-1:0]  landmarks_in_use,
	input  logic                          clearing,
	input  logic [lbe_pkg::DUR_BITS-1:0]  best,
	output logic                          busy,
	output logic                          clr_best,
	output lbe_pkg::wr_req_t              wr,
	output lbe_pkg::rd_req_t              rd,
	output logic                          done,
	output logic [lbe_pkg::DUR_BITS-1:0]  lower_bound
);
	import lbe_pkg::*;

	state_t               state_q, state_d;
	logic [CNT_BITS-1:0]  lm_cnt_q;
	logic [CNT_BITS-1:0]  n_q;
	logic [1:0]           drain_q;
	logic [STOP_BITS-1:0] s1_q, s2_q;
	logic                 done_q;
	logic [DUR_BITS-1:0]  lb_q;
	logic                 accept, issue, finish;
	logic [CNT_BITS-1:0]  n_clamped;

	assign n_clamped = (landmarks_in_use > CFG_BITS'(MAX_LANDMARKS)) ? LM_LIMIT
		: CNT_BITS'(landmarks_in_use);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (!clearing) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start && func == FUNC_QUERY) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (lm_cnt_q >= n_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q == 2'd2) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		busy     = (state_q != ST_IDLE);
		accept   = start && (state_q == ST_IDLE);
		clr_best = accept && func == FUNC_QUERY;
		issue    = (state_q == ST_READ) && (lm_cnt_q < n_q);
		finish   = (state_q == ST_DRAIN) && (drain_q == 2'd2);
		wr.valid = accept && func == FUNC_WRITE;
		wr.dir   = direction;
		wr.addr  = {landmark_index, stop_index};
		wr.entry = duration_known ? entry_t'{known: 1'b1, dur: duration_value} : '0;
		rd.valid = issue;
		rd.lm    = lm_cnt_q[LM_BITS-1:0];
		rd.s1    = s1_q;
		rd.s2    = s2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			lm_cnt_q <= '0;
			n_q      <= '0;
			drain_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (clr_best) begin
				lm_cnt_q <= '0;
				n_q      <= n_clamped;
				drain_q  <= '0;
			end else begin
				if (issue) begin
					lm_cnt_q <= lm_cnt_q + CNT_BITS'(1);
				end
				if (state_q == ST_DRAIN) begin
					drain_q <= drain_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_best) begin
			s1_q <= stop_index;
			s2_q <= second_stop;
		end
		if (finish) begin
			lb_q <= best;
		end
	end

	assign done        = done_q;
	assign lower_bound = lb_q;

endmodule

/* rtl/lbe_checker.sv */
// ----------------------------------------------------------------------------
// lbe_checker
// Port-level checks of the command handshake and result timing, bound to the
// top level.
// ----------------------------------------------------------------------------
module lbe_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic func,
	input logic done
);
	import lbe_pkg::*;

	// a query keeps the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_QUERY |=> busy)
		else $error("query accepted but busy not raised");

	// a write neither blocks nor yields a word
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_WRITE |=> !busy && !done)
		else $error("write raised busy or done");

	// a word only closes a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done without preceding busy period");

	// one word per query
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

endmodule

bind landmark_lower_bound_engine_top lbe_checker u_lbe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.func   (func),
	.done   (done)
);
